>>> rtl/aopb_pkg.sv
// ----------------------------------------------------------------------------
// aopb_pkg
// types, register indexes and helpers shared by the alpha-over blender
// ----------------------------------------------------------------------------
package aopb_pkg;

    typedef struct packed {
        logic [7:0] fg_red;
        logic [7:0] fg_green;
        logic [7:0] fg_blue;
        logic [7:0] fg_alpha;
        logic [7:0] bg_red;
        logic [7:0] bg_green;
        logic [7:0] bg_blue;
        logic [7:0] bg_alpha;
        logic       last_pixel;
    } t_in_pixel;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_last;
    } t_out_pixel;

    typedef struct packed {
        logic [7:0] fixed_alpha_fg;
        logic [7:0] fixed_alpha_bg;
        logic       has_alpha;
        logic       use_fixed_alpha;
    } t_cfg;

    // one blend job: three numerators and the common divisor
    typedef struct packed {
        logic [2:0][15:0] num;
        logic [7:0]       aout;
        logic             has_alpha;
        logic             last;
    } t_job;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FIXED_ALPHA_FG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_ALPHA_BG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USE_FIXED_ALPHA = 2'd3;

    localparam int JOBQ_DEPTH = 4;
    localparam int DIV_STEPS  = 8;
    localparam int OBUF_DEPTH = 16;

    // exact floor(x / 255) for x up to 255*255, the largest alpha product
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] y;
        y = 17'(x) + 17'(x >> 8) + 17'd1;
        return y[15:8];
    endfunction

endpackage

>>> rtl/aopb_front.sv
// ----------------------------------------------------------------------------
// aopb_front
// picks the alphas, forms combined alpha and the three blend numerators
// ----------------------------------------------------------------------------
module aopb_front
    import aopb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_pixel i_pixel,
    input  t_cfg      i_cfg,
    output logic      o_job_valid,
    input  logic      i_job_ready,
    output t_job      o_job
);

    logic        r_v1, r_v2, r_v3;
    t_in_pixel   r_px1, r_px2;
    logic [7:0]  r_af1, r_ab1, r_af2, r_abm2, r_aout2;
    logic [15:0] r_prod1;
    logic        r_ha1, r_ha2;
    t_job        r_job3;

    logic        rdy1, rdy2, rdy3;
    logic        use_fixed;
    logic [7:0]  n_af, n_ab, mult;
    logic [8:0]  asum;

    assign rdy3 = !r_v3 || i_job_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_full = !rdy1;

    // with no alpha byte the fixed registers always apply
    assign use_fixed = i_cfg.use_fixed_alpha || !i_cfg.has_alpha;
    assign n_af = use_fixed ? i_cfg.fixed_alpha_fg : i_pixel.fg_alpha;
    assign n_ab = use_fixed ? i_cfg.fixed_alpha_bg : i_pixel.bg_alpha;

    assign mult = div255(r_prod1);
    assign asum = 9'(r_af1) + 9'(r_ab1) - 9'(mult);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_push;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_px1   <= i_pixel;
            r_af1   <= n_af;
            r_ab1   <= n_ab;
            r_prod1 <= 16'(n_af) * 16'(n_ab);
            r_ha1   <= i_cfg.has_alpha;
        end
        if (rdy2) begin
            r_px2   <= r_px1;
            r_af2   <= r_af1;
            r_abm2  <= r_ab1 - mult;
            r_aout2 <= asum[7:0];
            r_ha2   <= r_ha1;
        end
        if (rdy3) begin
            r_job3.num[0]    <= 16'(r_px2.fg_red) * 16'(r_af2)
                              + 16'(r_px2.bg_red) * 16'(r_abm2);
            r_job3.num[1]    <= 16'(r_px2.fg_green) * 16'(r_af2)
                              + 16'(r_px2.bg_green) * 16'(r_abm2);
            r_job3.num[2]    <= 16'(r_px2.fg_blue) * 16'(r_af2)
                              + 16'(r_px2.bg_blue) * 16'(r_abm2);
            r_job3.aout      <= r_aout2;
            r_job3.has_alpha <= r_ha2;
            r_job3.last      <= r_px2.last_pixel;
        end
    end

    assign o_job_valid = r_v3;
    assign o_job       = r_job3;

endmodule

>>> rtl/aopb_jobq.sv
// ----------------------------------------------------------------------------
// aopb_jobq
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module aopb_jobq
    import aopb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int PW = $clog2(JOBQ_DEPTH);

    t_job            r_mem [JOBQ_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            do_push, do_pop;

    assign o_ready = (r_cnt != (PW+1)'(JOBQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

endmodule

>>> rtl/aopb_back.sv
// ----------------------------------------------------------------------------
// aopb_back
// pipelined restoring divider, one quotient bit per stage, and result buffer
// ----------------------------------------------------------------------------
module aopb_back
    import aopb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    output logic       o_job_pop,
    input  t_job       i_job,
    output logic       o_empty,
    input  logic       i_pop,
    output t_out_pixel o_pixel
);

    localparam int OW = $clog2(OBUF_DEPTH);
    localparam int FW = $clog2(DIV_STEPS + 2);

    logic                  r_vs   [DIV_STEPS+1];
    logic [2:0][15:0]      r_rem  [DIV_STEPS+1];
    logic [2:0][7:0]       r_q    [DIV_STEPS+1];
    logic [7:0]            r_d    [DIV_STEPS+1];
    logic                  r_ha   [DIV_STEPS+1];
    logic                  r_last [DIV_STEPS+1];

    logic [2:0][15:0]      n_rem  [DIV_STEPS+1];
    logic [2:0][7:0]       n_q    [DIV_STEPS+1];

    t_out_pixel            r_mem [OBUF_DEPTH];
    logic [OW-1:0]         r_wp, r_rp;
    logic [OW:0]           r_cnt;
    logic [FW-1:0]         r_inflight;
    logic [OW+1:0]         occ;
    logic                  issue, do_pop, done;
    t_out_pixel            res;

    // every job in the divider has a reserved slot in the buffer
    assign occ       = (OW+2)'(r_cnt) + (OW+2)'(r_inflight);
    assign issue     = i_job_valid && (occ < (OW+2)'(OBUF_DEPTH));
    assign o_job_pop = issue;
    assign done      = r_vs[DIV_STEPS];
    assign do_pop    = i_pop && (r_cnt != '0);
    assign o_empty   = (r_cnt == '0);
    assign o_pixel   = r_mem[r_rp];

    always_comb begin
        logic [15:0] dsh;
        n_rem[0] = i_job.num;
        n_q[0]   = '0;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            dsh = 16'(r_d[s-1]) << (DIV_STEPS - s);
            for (int c = 0; c < 3; c++) begin
                n_rem[s][c] = r_rem[s-1][c];
                n_q[s][c]   = r_q[s-1][c];
                if (r_rem[s-1][c] >= dsh) begin
                    n_rem[s][c] = r_rem[s-1][c] - dsh;
                    n_q[s][c][DIV_STEPS-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STEPS; s++) r_vs[s] <= 1'b0;
        end else begin
            r_vs[0] <= issue;
            for (int s = 1; s <= DIV_STEPS; s++) r_vs[s] <= r_vs[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_rem[0];
        r_q[0]    <= n_q[0];
        r_d[0]    <= i_job.aout;
        r_ha[0]   <= i_job.has_alpha;
        r_last[0] <= i_job.last;
        for (int s = 1; s <= DIV_STEPS; s++) begin
            r_rem[s]  <= n_rem[s];
            r_q[s]    <= n_q[s];
            r_d[s]    <= r_d[s-1];
            r_ha[s]   <= r_ha[s-1];
            r_last[s] <= r_last[s-1];
        end
    end

    // zero combined alpha gives a black, transparent pixel
    always_comb begin
        logic zero;
        zero          = (r_d[DIV_STEPS] == '0);
        res.out_red   = zero ? 8'd0 : r_q[DIV_STEPS][0];
        res.out_green = zero ? 8'd0 : r_q[DIV_STEPS][1];
        res.out_blue  = zero ? 8'd0 : r_q[DIV_STEPS][2];
        res.out_alpha = r_ha[DIV_STEPS] ? r_d[DIV_STEPS] : 8'd0;
        res.out_last  = r_last[DIV_STEPS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
            r_inflight <= '0;
        end else begin
            if (done)   r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt      <= r_cnt + (OW+1)'(done) - (OW+1)'(do_pop);
            r_inflight <= r_inflight + FW'(issue) - FW'(done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_mem[r_wp] <= res;
    end

endmodule

>>> rtl/alpha_over_pixel_blender.sv
// ----------------------------------------------------------------------------
// alpha_over_pixel_blender
// porter-duff over blend of one rgba8888 pixel pair per transaction
// ----------------------------------------------------------------------------
//  channel   ports                           direction
//  input     push, full, i_pixel             in
//  result    empty, pop, o_pixel             out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data in
//
//  one pixel per clock sustained while pop keeps up; from push to empty low a pixel
//  passes 3 front stages, the job queue, the 9-stage divider and the buffer write
//  synchronous active-low reset clears all control state and presets the config registers
//  the result buffer holds 16 pixels; a stalled pop backs up through the
//  divider credits, the job queue and the front pipeline to full
// ----------------------------------------------------------------------------
module alpha_over_pixel_blender
    import aopb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_pixel             i_pixel,
    output logic                  empty,
    input  logic                  pop,
    output t_out_pixel            o_pixel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic job_valid, job_ready, jq_valid, jq_pop;
    t_job job, jq_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fixed_alpha_fg  <= 8'd255;
            r_cfg.fixed_alpha_bg  <= 8'd255;
            r_cfg.has_alpha       <= 1'b1;
            r_cfg.use_fixed_alpha <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FIXED_ALPHA_FG:  r_cfg.fixed_alpha_fg  <= i_cfg_data;
                REG_FIXED_ALPHA_BG:  r_cfg.fixed_alpha_bg  <= i_cfg_data;
                REG_HAS_ALPHA:       r_cfg.has_alpha       <= i_cfg_data[0];
                REG_USE_FIXED_ALPHA: r_cfg.use_fixed_alpha <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    aopb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_pixel     (i_pixel),
        .i_cfg       (r_cfg),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    aopb_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .o_ready (job_ready),
        .i_job   (job),
        .o_valid (jq_valid),
        .i_pop   (jq_pop),
        .o_job   (jq_job)
    );

    aopb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (jq_valid),
        .o_job_pop   (jq_pop),
        .i_job       (jq_job),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_pixel     (o_pixel)
    );

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jq_pop |-> jq_valid)
        else $error("job taken from empty queue");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid && !job_ready |=> job_valid && $stable(job))
        else $error("stalled job changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("not idle after reset");

endmodule
